FILE: src/bio3_pkg.sv
// ----------------------------------------------------------------------------
// bio3_pkg: shared definitions for the binary inner outline block
// Sizes, register indexes and the control records passed between modules.
// ----------------------------------------------------------------------------
package bio3_pkg;

    // image limits and field widths
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int POS_W      = 10;   // row and column index width
    localparam int DIM_W      = 11;   // register and counter width
    localparam int CFG_IDX_W  = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // line store entry: bit 0 two rows up, bit 1 one row up
    typedef logic [1:0] t_lb_word;

    // line store write request
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
        t_lb_word         data;
    } t_lb_wr;

    // line store read request
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] addr;
    } t_lb_rd;

    // window column cell control
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

FILE: src/bio3_line_buf.sv
// ----------------------------------------------------------------------------
// bio3_line_buf: two-row line store
// One memory word per column holds the two previous rows; registered read
// with bypass of a write that lands on the same edge as the read.
// ----------------------------------------------------------------------------
module bio3_line_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bio3_pkg::t_lb_rd i_rd,
    input  bio3_pkg::t_lb_wr i_wr,
    output bio3_pkg::t_lb_word o_rd_data
);
    import bio3_pkg::*;

    t_lb_word r_mem [MAX_WIDTH];
    t_lb_word r_q;
    t_lb_word r_fwd_data;
    logic     r_fwd;

    // memory write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read, held until the next read request
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_q        <= r_mem[i_rd.addr];
            r_fwd_data <= i_wr.data;
        end
    end

    // bypass flag for a same-edge write to the read column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd.en) begin
            r_fwd <= i_wr.en && (i_wr.addr == i_rd.addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_q;

endmodule

FILE: src/bio3_col_cell.sv
// ----------------------------------------------------------------------------
// bio3_col_cell: one column of the 3x3 window
// Holds three vertical bits and hands them to its left neighbor on a shift.
// ----------------------------------------------------------------------------
module bio3_col_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bio3_pkg::t_cell_ctrl i_ctrl,
    input  logic [2:0]           i_col,
    output logic [2:0]           o_col
);
    import bio3_pkg::*;

    logic [2:0] r_col;

    // column storage: bit 0 top, bit 2 bottom
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_ctrl.clear) begin
            r_col <= '0;
        end else if (i_ctrl.shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

FILE: src/binary_inner_outline_3x3_core.sv
// ----------------------------------------------------------------------------
// binary_inner_outline_3x3_core: streaming 3x3 inner outline of a binary image
// Line store plus a chain of two window column cells; each pixel is XORed
// with its 3x3 erosion, neighbors outside the image left out.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle, pixels and flushes alike, while the
//   result side takes the results; the result of a pixel leaves with the
//   request image_width+1 positions later.
// Pipeline: accept edge reads the line store; the edge on which stage 1
//   advances shifts the window and loads the output register.
// Reset: synchronous, active low; clears counters, window and handshake
//   state, registers return to 1024; line store contents are not cleared.
// ----------------------------------------------------------------------------
module binary_inner_outline_3x3_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [bio3_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bio3_pkg::DIM_W-1:0]     i_cfg_data,
    // pixel requests
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [0] pixel_value
    input  logic [0:0]                     s_axis_tuser,   // [0] flush_tick
    // outline results
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata,   // [0] outline_bit,
                                                           // [10:1] out_row,
                                                           // [20:11] out_col
    output logic                           m_axis_tlast    // frame_end
);
    import bio3_pkg::*;

    // configuration and position state
    logic [DIM_W-1:0] r_width, r_height;
    logic [POS_W-1:0] r_in_col, r_in_line, r_em_col, r_em_line;
    logic [DIM_W-1:0] r_lag, r_pend;

    // stage 1 state
    logic             r_s1_valid, r_s1_emit, r_s1_shift, r_s1_write, r_s1_pix;
    logic [POS_W-1:0] r_s1_addr, r_s1_row, r_s1_col;
    logic [3:0]       r_s1_mask;   // top row, bottom row, left col, right col
    logic             r_s1_last;

    // output register
    logic             r_o_valid;
    logic [23:0]      r_o_data;
    logic             r_o_last;

    // next values of stage 0 state
    logic [POS_W-1:0] n_in_col, n_in_line, n_em_col, n_em_line;
    logic [DIM_W-1:0] n_lag, n_pend;

    logic [DIM_W-1:0] w_dim, h_dim, w_plus1, k_cnt;
    logic [DIM_W-1:0] lag_b, pend_b;
    logic [POS_W-1:0] em_col_b, em_line_b, rd_addr;
    logic             is_pix, flush_ok, emit, shift, accept, out_free, s1_adv;
    logic [3:0]       mask;
    logic             last;

    t_lb_rd     lb_rd;
    t_lb_wr     lb_wr;
    t_lb_word   lb_q;
    t_cell_ctrl cell_ctrl;
    logic [2:0] stack, col1, col2;
    logic [8:0] n_win;
    logic       ero, outline;

    // clamped image dimensions
    always_comb begin
        priority if (r_width == '0) begin
            w_dim = DIM_W'(1);
        end else if (r_width > DIM_W'(MAX_WIDTH)) begin
            w_dim = DIM_W'(MAX_WIDTH);
        end else begin
            w_dim = r_width;
        end
        priority if (r_height == '0) begin
            h_dim = DIM_W'(1);
        end else if (r_height > DIM_W'(MAX_HEIGHT)) begin
            h_dim = DIM_W'(MAX_HEIGHT);
        end else begin
            h_dim = r_height;
        end
    end

    assign w_plus1 = w_dim + DIM_W'(1);
    assign k_cnt   = r_lag - r_pend;

    // handshake
    assign out_free      = !r_o_valid || m_axis_tready;
    assign s1_adv        = r_s1_valid && (!r_s1_emit || out_free);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_pix        = !s_axis_tuser[0];

    // stage 0: counters, emit decision and read column
    always_comb begin
        flush_ok = (r_pend != '0) && (r_in_col == '0) && (r_in_line == '0);
        // a pixel after partial flushing starts over at the input position
        if (is_pix && (r_lag != r_pend)) begin
            lag_b     = '0;
            pend_b    = '0;
            em_col_b  = r_in_col;
            em_line_b = r_in_line;
        end else begin
            lag_b     = r_lag;
            pend_b    = r_pend;
            em_col_b  = r_em_col;
            em_line_b = r_em_line;
        end
        shift = is_pix || flush_ok;
        emit  = shift && (lag_b == w_plus1);

        // read column
        if (is_pix) begin
            rd_addr = r_in_col;
        end else if (k_cnt < w_dim) begin
            rd_addr = k_cnt[POS_W-1:0];
        end else begin
            rd_addr = '0;
        end

        // lag and pending counts
        n_lag  = lag_b;
        n_pend = pend_b;
        if (shift && !emit) begin
            n_lag = lag_b + DIM_W'(1);
        end
        if (is_pix && !emit) begin
            n_pend = pend_b + DIM_W'(1);
        end else if (!is_pix && emit) begin
            n_pend = pend_b - DIM_W'(1);
        end

        // border masks and end of image for the emitted position
        mask[0] = em_line_b != '0;
        mask[1] = ({1'b0, em_line_b} + DIM_W'(1)) < h_dim;
        mask[2] = em_col_b != '0;
        mask[3] = ({1'b0, em_col_b} + DIM_W'(1)) < w_dim;
        last    = (({1'b0, em_line_b} + DIM_W'(1)) == h_dim)
               && (({1'b0, em_col_b} + DIM_W'(1)) == w_dim);

        // emit position advance
        n_em_col  = em_col_b;
        n_em_line = em_line_b;
        if (emit) begin
            if (({1'b0, em_col_b} + DIM_W'(1)) >= w_dim) begin
                n_em_col = '0;
                if (({1'b0, em_line_b} + DIM_W'(1)) >= h_dim) begin
                    n_em_line = '0;
                end else begin
                    n_em_line = em_line_b + POS_W'(1);
                end
            end else begin
                n_em_col = em_col_b + POS_W'(1);
            end
        end

        // input position advance
        n_in_col  = r_in_col;
        n_in_line = r_in_line;
        if (is_pix) begin
            if (({1'b0, r_in_col} + DIM_W'(1)) >= w_dim) begin
                n_in_col = '0;
                if (({1'b0, r_in_line} + DIM_W'(1)) >= h_dim) begin
                    n_in_line = '0;
                end else begin
                    n_in_line = r_in_line + POS_W'(1);
                end
            end else begin
                n_in_col = r_in_col + POS_W'(1);
            end
        end
    end

    // configuration and stage 0 state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= DIM_W'(MAX_WIDTH);
            r_height  <= DIM_W'(MAX_HEIGHT);
            r_in_col  <= '0;
            r_in_line <= '0;
            r_em_col  <= '0;
            r_em_line <= '0;
            r_lag     <= '0;
            r_pend    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default:          r_width  <= r_width;
            endcase
            r_in_col  <= '0;
            r_in_line <= '0;
            r_em_col  <= '0;
            r_em_line <= '0;
            r_lag     <= '0;
            r_pend    <= '0;
        end else if (accept) begin
            r_in_col  <= n_in_col;
            r_in_line <= n_in_line;
            r_em_col  <= n_em_col;
            r_em_line <= n_em_line;
            r_lag     <= n_lag;
            r_pend    <= n_pend;
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit  <= emit;
            r_s1_shift <= shift;
            r_s1_write <= is_pix;
            r_s1_pix   <= is_pix && s_axis_tdata[0];
            r_s1_addr  <= rd_addr;
            r_s1_row   <= em_line_b;
            r_s1_col   <= em_col_b;
            r_s1_mask  <= mask;
            r_s1_last  <= last;
        end
    end

    // line store access
    assign lb_rd.en   = accept;
    assign lb_rd.addr = rd_addr;
    assign lb_wr.en   = s1_adv && r_s1_write;
    assign lb_wr.addr = r_s1_addr;
    assign lb_wr.data = {r_s1_pix, lb_q[1]};

    bio3_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (lb_rd),
        .i_wr      (lb_wr),
        .o_rd_data (lb_q)
    );

    // window column chain: new column enters on the right
    assign stack           = {r_s1_pix, lb_q[1], lb_q[0]};
    assign cell_ctrl.shift = s1_adv && r_s1_shift;
    assign cell_ctrl.clear = i_cfg_we;

    bio3_col_cell u_cell_right (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctrl (cell_ctrl),
        .i_col (stack), .o_col (col2)
    );

    bio3_col_cell u_cell_mid (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_ctrl (cell_ctrl),
        .i_col (col2), .o_col (col1)
    );

    // erosion over the shifted window, border neighbors left out
    always_comb begin
        n_win = {stack, col2, col1};
        ero   = 1'b1;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (((r != 0) || r_s1_mask[0]) && ((r != 2) || r_s1_mask[1])
                    && ((c != 0) || r_s1_mask[2]) && ((c != 2) || r_s1_mask[3])
                    && !n_win[c*3 + r]) begin
                    ero = 1'b0;
                end
            end
        end
        outline = n_win[4] ^ ero;
    end

    // output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv && r_s1_emit) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_emit) begin
            r_o_data <= {3'b000, r_s1_col, r_s1_row, outline};
            r_o_last <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;

endmodule

FILE: dv/bio3_outline_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bio3_outline_checker: scoreboard for the binary inner outline core
// Watches the register port and both stream channels, keeps its own line
// stores and 3x3 window, predicts each outline result and compares it field
// by field with what the core hands out.
// ----------------------------------------------------------------------------
module bio3_outline_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bio3_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bio3_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [0] pixel_value
    input  logic [0:0]                     s_axis_tuser,   // [0] flush_tick
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [23:0]                    m_axis_tdata,   // [0] outline_bit,
                                                           // [10:1] out_row,
                                                           // [20:11] out_col
    input  logic                           m_axis_tlast,   // frame_end
    output int                             o_mismatches,
    output int                             o_pending,
    output int                             o_results
);
    import bio3_pkg::*;

    typedef struct packed {
        logic             outline;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_outline;

    // shadow registers and pipeline state
    logic [DIM_W-1:0] width_reg  = DIM_W'(MAX_WIDTH);
    logic [DIM_W-1:0] height_reg = DIM_W'(MAX_HEIGHT);
    bit               upper_line [MAX_WIDTH];
    bit               lower_line [MAX_WIDTH];
    logic [8:0]       window;
    int unsigned      in_col, in_row, emit_col, emit_row;
    int unsigned      lag_cnt, pend_cnt;

    t_outline         pending_outlines [$];
    int               mismatches;
    int               results;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_results    = 0;
        mismatches   = 0;
        results      = 0;
    end

    // start of frame: positions, counters and window back to zero
    function automatic void clear_frame();
        in_col   = 0;
        in_row   = 0;
        emit_col = 0;
        emit_row = 0;
        lag_cnt  = 0;
        pend_cnt = 0;
        window   = '0;
    endfunction

    // raster step with wrap at the frame end
    function automatic void step_position(inout int unsigned col, inout int unsigned row,
                                          input int unsigned w, input int unsigned h);
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h)
                row = 0;
        end
    endfunction

    // shift one column into the window and emit an outline bit once primed
    function automatic void slide_window(input logic [2:0] stack, input bit from_pixel,
                                         input int unsigned w, input int unsigned h);
        int unsigned prior;
        bit          row_ok [3];
        bit          col_ok [3];
        logic        erosion;
        t_outline    res;

        prior   = lag_cnt;
        window  = {stack, window[8:3]};
        lag_cnt++;
        if (from_pixel)
            pend_cnt++;
        if (prior != w + 1 || pend_cnt == 0)
            return;

        // neighbors outside the image do not take part in the erosion
        row_ok[0] = emit_row > 0;
        row_ok[1] = 1'b1;
        row_ok[2] = emit_row + 1 < h;
        col_ok[0] = emit_col > 0;
        col_ok[1] = 1'b1;
        col_ok[2] = emit_col + 1 < w;
        erosion = 1'b1;
        for (int c = 0; c < 3; c++)
            for (int r = 0; r < 3; r++)
                if (row_ok[r] && col_ok[c] && !window[c * 3 + r])
                    erosion = 1'b0;

        res.outline = window[4] ^ erosion;
        res.row     = emit_row[POS_W-1:0];
        res.col     = emit_col[POS_W-1:0];
        res.last    = (emit_row + 1 == h) && (emit_col + 1 == w);
        pending_outlines.push_back(res);
        step_position(emit_col, emit_row, w, h);
        lag_cnt--;
        pend_cnt--;
    endfunction

    // work out what one accepted request produces
    function automatic void predict_request(input logic pix, input logic flush);
        int unsigned w, h, c, k;

        w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);

        if (!flush) begin
            // a pixel after partial flushing drops what is left and starts over
            if (lag_cnt != pend_cnt) begin
                lag_cnt  = 0;
                pend_cnt = 0;
                emit_col = in_col;
                emit_row = in_row;
            end
            c = in_col;
            slide_window({pix, lower_line[c], upper_line[c]}, 1'b1, w, h);
            upper_line[c] = lower_line[c];
            lower_line[c] = pix;
            step_position(in_col, in_row, w, h);
        end else if (pend_cnt > 0 && in_col == 0 && in_row == 0) begin
            k = lag_cnt - pend_cnt;
            c = (k < w) ? k : 0;
            slide_window({1'b0, lower_line[c], upper_line[c]}, 1'b0, w, h);
        end
    endfunction

    // compare one delivered outline with the oldest prediction
    function automatic void check_outline();
        t_outline got, want;

        got.outline = m_axis_tdata[0];
        got.row     = m_axis_tdata[10:1];
        got.col     = m_axis_tdata[20:11];
        got.last    = m_axis_tlast;
        results++;
        if (pending_outlines.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%t unexpected outline: bit %0d row %0d col %0d last %0d",
                         $realtime, got.outline, got.row, got.col, got.last);
            return;
        end
        want = pending_outlines.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%t outline mismatch: expected bit %0d row %0d col %0d last %0d, %s",
                         $realtime, want.outline, want.row, want.col, want.last,
                         $sformatf("got bit %0d row %0d col %0d last %0d",
                                   got.outline, got.row, got.col, got.last));
        end
    endfunction

    // sample every channel at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = DIM_W'(MAX_WIDTH);
            height_reg = DIM_W'(MAX_HEIGHT);
            clear_frame();
            pending_outlines.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_IMAGE_WIDTH)
                    width_reg = i_cfg_data;
                else
                    height_reg = i_cfg_data;
                clear_frame();
            end
            if (m_axis_tvalid && m_axis_tready)
                check_outline();
            if (s_axis_tvalid && s_axis_tready)
                predict_request(s_axis_tdata[0], s_axis_tuser[0]);
        end
        o_pending    <= pending_outlines.size();
        o_mismatches <= mismatches;
        o_results    <= results;
    end

endmodule

FILE: dv/binary_inner_outline_3x3_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_inner_outline_3x3_core_tb: stimulus and verdict for the outline core
// Drives binary frames, flushes and register writes into the core while the
// result side stalls at random; the checker beside the core predicts every
// outline result and counts mismatches.
// ----------------------------------------------------------------------------
module binary_inner_outline_3x3_core_tb;
    import bio3_pkg::*;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [DIM_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata  = '0;   // [0] pixel_value
    logic [0:0]           s_axis_tuser  = '0;   // [0] flush_tick
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [23:0]          m_axis_tdata;         // [0] outline_bit, [10:1] out_row,
                                                // [20:11] out_col
    logic                 m_axis_tlast;         // frame_end

    int                   mismatches;
    int                   pending;
    int                   results;

    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    logic                 hold_req      = 1'b0;
    bit                   hold_done     = 1'b0;
    int                   hold_left     = 0;
    int                   requests_sent = 0;
    int                   pixels_sent   = 0;

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    binary_inner_outline_3x3_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    bio3_outline_checker u_outline_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_results     (results)
    );

    // result side: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            hold_done     <= 1'b1;
            hold_left     <= 400;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one request, each idle cycle ahead of it drawn at random
    task automatic offer(input logic pix, input logic flush);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, pix};
        s_axis_tuser  <= flush;
        do @(posedge i_clk); while (!s_axis_tready);
        requests_sent++;
        if (!flush)
            pixels_sent++;
    endtask

    task automatic send_flushes(input int n);
        repeat (n) offer(1'($urandom_range(1)), 1'b1);
    endtask

    // one frame of random pixels, now and then a stray flush in between
    task automatic send_frame(input int cols, input int rows);
        int dens;
        dens = 10 + 40 * $urandom_range(2);
        for (int i = 0; i < cols * rows; i++) begin
            if ($urandom_range(49) == 0)
                offer(1'($urandom_range(1)), 1'b1);
            offer($urandom_range(99) < dens, 1'b0);
        end
    endtask

    // stop sending until every predicted outline is out, then let the core settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        for (int n = 0; n < 20000 && pending != 0; n++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_dims(input int w, input int h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_IMAGE_WIDTH;
        i_cfg_data <= w[DIM_W-1:0];
        @(posedge i_clk);
        i_cfg_idx  <= REG_IMAGE_HEIGHT;
        i_cfg_data <= h[DIM_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // small random frame set: noise, back to back frames, partial flushing
    task automatic run_job();
        int w, h, fw, fh, kind, frames, n;
        drain();
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 8);
        if ($urandom_range(11) == 0)
            w = 0;
        if ($urandom_range(11) == 0)
            h = 0;
        write_dims(w, h);
        fw   = (w == 0) ? 1 : w;
        fh   = (h == 0) ? 1 : h;
        kind = $urandom_range(9);
        if (kind == 0) begin
            n = $urandom_range(5, 30);
            repeat (n) offer(1'($urandom_range(1)), $urandom_range(99) < 30);
        end else begin
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++) begin
                send_frame(fw, fh);
                if (kind == 1 && f + 1 < frames)
                    send_flushes($urandom_range(1, fw));
            end
            send_flushes(fw + 1 + $urandom_range(1));
        end
    endtask

    // timeout
    initial begin
        #1000000;
        $display("binary_inner_outline_3x3_core verification failed");
        $finish;
    end

    initial begin
        int ext_w [4];
        int ext_h [4];
        int fw, fh;

        ext_w = '{2047, 3, 0, 4};
        ext_h = '{2, 2047, 3, 0};

        send_idle_pct = 23;
        recv_idle_pct <= 52;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: restart by a register write, stray flushes, 3x3 frame
        write_dims(3, 3);
        offer(1'b1, 1'b0);
        offer(1'b1, 1'b0);
        offer(1'b1, 1'b1);
        drain();
        write_dims(3, 3);
        offer(1'b1, 1'b0);
        offer(1'b1, 1'b0);
        offer(1'b0, 1'b0);
        offer(1'b1, 1'b0);
        offer(1'b1, 1'b1);
        offer(1'b1, 1'b0);
        offer(1'b1, 1'b0);
        offer(1'b1, 1'b0);
        offer(1'b1, 1'b0);
        offer(1'b1, 1'b0);
        send_flushes(5);
        // directed: single row frame
        drain();
        write_dims(2, 1);
        offer(1'b1, 1'b0);
        offer(1'b0, 1'b0);
        send_flushes(3);

        // random, sender idles lightly and receiver heavily
        while (requests_sent < 300)
            run_job();

        // random, the other way round
        send_idle_pct = 52;
        recv_idle_pct <= 23;
        while (requests_sent < 600)
            run_job();

        // no idling: long receiver hold-off while the sender keeps going
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        drain();
        write_dims(16, 20);
        hold_req <= 1'b1;
        send_frame(16, 20);
        send_flushes(17);
        while (requests_sent < 1060)
            run_job();

        // register values out of range; large clamped frames only partly sent
        for (int i = 0; i < 4; i++) begin
            drain();
            write_dims(ext_w[i], ext_h[i]);
            fw = (ext_w[i] == 0) ? 1 : ((ext_w[i] > MAX_WIDTH) ? MAX_WIDTH : ext_w[i]);
            fh = (ext_h[i] == 0) ? 1 : ((ext_h[i] > MAX_HEIGHT) ? MAX_HEIGHT : ext_h[i]);
            if (fw * fh <= 48) begin
                send_frame(fw, fh);
                send_flushes(fw + 1);
            end else begin
                for (int p = 0; p < 48; p++)
                    offer(1'($urandom_range(1)), 1'b0);
            end
        end

        drain();
        $display("run: %0d requests (%0d pixels), %0d outline results checked",
                 requests_sent, pixels_sent, results);
        $display("frames from 1x1 up to 16x20 and clamped register values, under random stalls");
        if (pending != 0)
            $display("%0d predicted outline results never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("binary_inner_outline_3x3_core verification clean");
        else
            $display("binary_inner_outline_3x3_core verification failed");
        $finish;
    end

endmodule
